>>> sv/segment_plane_intersection_defines.svh
// assertion helpers for the segment against plane block
`ifndef SEGMENT_PLANE_INTERSECTION_DEFINES_SVH
`define SEGMENT_PLANE_INTERSECTION_DEFINES_SVH

// same cycle implication
`define SPI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next cycle implication
`define SPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/spi_pkg.sv
package spi_pkg;

  localparam int DOT_W = 66;
  localparam int Q_W   = 30;
  localparam int REM_W = DOT_W + Q_W + 1;

  localparam int IN_W  = 320;
  localparam int OUT_W = 104;

  typedef enum logic [1:0] {
    ST_INTERSECT = 2'd0,
    ST_COPLANAR  = 2'd1,
    ST_DISJOINT  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_POINT  = 2'd0,
    K_VERT_A = 2'd1,
    K_VERT_B = 2'd2,
    K_STATUS = 2'd3
  } kind_t;

  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [2:0][32:0] dir;
    kind_t            kind;
    status_t          st;
    logic             neg;
    logic             zero_t;
  } side_t;

endpackage

>>> sv/segment_plane_intersection.sv
// channel  dir  payload (lowest bit first)                               width
// in_      in   start_x/y/z, end_x/y/z, normal_x/y/z, plane_offset       320
// out_     out  status, hit_x, hit_y, hit_z, zero pad                    104
// cfg_     in   index 0 epsilon, index 1 fast_mode                       16
//
// one transfer per cycle in, one result per cycle out, except while a held result stalls the pipe
// pipeline: 5 dot product stages, 31 divider stages, 3 lerp stages
// the divider resolves one quotient bit a stage, which sets the depth
// synchronous active-low reset clears valid bits and config to defaults
// a result held with out_tready low freezes the whole pipe and drops in_tready
`include "segment_plane_intersection_defines.svh"

module segment_plane_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, normal_x, normal_y, normal_z, plane_offset
  input  logic [spi_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // status, hit_x, hit_y, hit_z, pad
  output logic [spi_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [15:0]                cfg_wdata
);
  import spi_pkg::*;

  localparam logic REG_EPSILON   = 1'b0;
  localparam logic REG_FAST_MODE = 1'b1;

  logic [15:0] eps_r;
  logic        fast_r;
  logic        en;

  logic             dot_valid, div_valid;
  side_t            dot_side, div_side;
  logic [DOT_W-1:0] num_mag, den_mag;
  logic [Q_W-1:0]   quot;
  status_t          status;
  logic [2:0][31:0] hit;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= 16'd16;
      fast_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EPSILON:   eps_r  <= cfg_wdata;
        REG_FAST_MODE: fast_r <= cfg_wdata[0];
        default:       ;
      endcase
    end
  end

  spi_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .epsilon   (eps_r),
    .fast_mode (fast_r),
    .out_valid (dot_valid),
    .out_side  (dot_side),
    .num_mag   (num_mag),
    .den_mag   (den_mag)
  );

  spi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dot_valid),
    .in_side   (dot_side),
    .num_mag   (num_mag),
    .den_mag   (den_mag),
    .out_valid (div_valid),
    .out_side  (div_side),
    .quot      (quot)
  );

  spi_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .in_side   (div_side),
    .quot      (quot),
    .out_valid (out_tvalid),
    .status    (status),
    .hit       (hit)
  );

  assign out_tdata = {6'd0, hit[2], hit[1], hit[0], status};

  `SPI_ASSERT_NOW(a_stall_blocks_input, out_tvalid && !out_tready, !in_tready, "input taken during stall")
  `SPI_ASSERT_NOW(a_status_legal, out_tvalid, out_tdata[1:0] == ST_INTERSECT || out_tdata[1:0] == ST_COPLANAR || out_tdata[1:0] == ST_DISJOINT, "bad status code")
  `SPI_ASSERT_NOW(a_miss_has_no_point, out_tvalid && out_tdata[1:0] != ST_INTERSECT, out_tdata[97:2] == '0, "point on non-intersect result")
  `SPI_ASSERT_NEXT(a_stall_holds_result, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

endmodule

>>> sv/spi_dot.sv
module spi_dot #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [spi_pkg::IN_W-1:0]   in_data,
  input  logic [15:0]                epsilon,
  input  logic                       fast_mode,
  output logic                       out_valid,
  output spi_pkg::side_t             out_side,
  output logic [spi_pkg::DOT_W-1:0]  num_mag,
  output logic [spi_pkg::DOT_W-1:0]  den_mag
);
  import spi_pkg::*;

  logic [5:1] v_r;

  logic signed [63:0] pa_prod_r [3];
  logic signed [63:0] pb_prod_r [3];
  logic [2:0][31:0]   a1_r, b1_r, a2_r, b2_r, a3_r, b3_r, a4_r, b4_r;
  logic [31:0]        d1_r, d2_r;
  logic signed [DOT_W-1:0] pa_r, pb_r, da_r, db_r, den_r;
  logic [2:0][32:0]   dir4_r;
  logic [DOT_W-1:0]   mda_r, mdb_r, mden_r;
  logic               da_neg_r, da_zero_r, den_neg_r, den_zero_r;
  side_t              side_r;
  logic [DOT_W-1:0]   num_mag_r, den_mag_r;

  logic signed [DOT_W-1:0] pa_nxt, pb_nxt, d_ext;
  logic [DOT_W-1:0]        eps_ext;
  side_t                   side_nxt;

  always_comb begin
    pa_nxt = '0;
    pb_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      pa_nxt = pa_nxt + {{(DOT_W-64){pa_prod_r[k][63]}}, (pa_prod_r[k] >>> FRAC_BITS)};
      pb_nxt = pb_nxt + {{(DOT_W-64){pb_prod_r[k][63]}}, (pb_prod_r[k] >>> FRAC_BITS)};
    end
    d_ext = {{(DOT_W-32){d2_r[31]}}, d2_r};
  end

  always_comb begin
    eps_ext         = {{(DOT_W-16){1'b0}}, epsilon};
    side_nxt.a      = a4_r;
    side_nxt.b      = b4_r;
    side_nxt.dir    = dir4_r;
    side_nxt.kind   = K_POINT;
    side_nxt.st     = ST_INTERSECT;
    side_nxt.neg    = 1'b0;
    side_nxt.zero_t = 1'b0;
    // numerator is -da
    if (fast_mode) begin
      side_nxt.neg    = (!da_neg_r && !da_zero_r) != den_neg_r;
      side_nxt.zero_t = den_zero_r;
    end else if (mden_r < eps_ext) begin
      side_nxt.kind = K_STATUS;
      side_nxt.st   = (mda_r < eps_ext) ? ST_COPLANAR : ST_DISJOINT;
    end else if (mda_r < eps_ext) begin
      side_nxt.kind = K_VERT_A;
    end else if (mdb_r < eps_ext) begin
      side_nxt.kind = K_VERT_B;
    end else if (den_zero_r) begin
      side_nxt.kind = K_VERT_A;
    end else if ((!da_zero_r && ((!da_neg_r) != den_neg_r)) || (mda_r > mden_r)) begin
      side_nxt.kind = K_STATUS;
      side_nxt.st   = ST_DISJOINT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pa_prod_r[k] <= $signed(in_data[32*k +: 32]) * $signed(in_data[32*(6+k) +: 32]);
        pb_prod_r[k] <= $signed(in_data[32*(3+k) +: 32]) * $signed(in_data[32*(6+k) +: 32]);
        a1_r[k]      <= in_data[32*k +: 32];
        b1_r[k]      <= in_data[32*(3+k) +: 32];
        dir4_r[k]    <= {b3_r[k][31], b3_r[k]} - {a3_r[k][31], a3_r[k]};
      end
      d1_r <= in_data[319:288];

      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      d2_r <= d1_r;
      a2_r <= a1_r;
      b2_r <= b1_r;

      da_r  <= pa_r - d_ext;
      db_r  <= pb_r - d_ext;
      den_r <= pb_r - pa_r;
      a3_r  <= a2_r;
      b3_r  <= b2_r;

      mda_r      <= da_r[DOT_W-1] ? DOT_W'(-da_r) : DOT_W'(da_r);
      mdb_r      <= db_r[DOT_W-1] ? DOT_W'(-db_r) : DOT_W'(db_r);
      mden_r     <= den_r[DOT_W-1] ? DOT_W'(-den_r) : DOT_W'(den_r);
      da_neg_r   <= da_r[DOT_W-1];
      da_zero_r  <= (da_r == '0);
      den_neg_r  <= den_r[DOT_W-1];
      den_zero_r <= (den_r == '0);
      a4_r       <= a3_r;
      b4_r       <= b3_r;

      side_r    <= side_nxt;
      num_mag_r <= mda_r;
      den_mag_r <= mden_r;
    end
  end

  assign out_valid = v_r[5];
  assign out_side  = side_r;
  assign num_mag   = num_mag_r;
  assign den_mag   = den_mag_r;

endmodule

>>> sv/spi_div.sv
module spi_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  spi_pkg::side_t             in_side,
  input  logic [spi_pkg::DOT_W-1:0]  num_mag,
  input  logic [spi_pkg::DOT_W-1:0]  den_mag,
  output logic                       out_valid,
  output spi_pkg::side_t             out_side,
  output logic [spi_pkg::Q_W-1:0]    quot
);
  import spi_pkg::*;

  // one quotient bit per stage, saturating at all ones
  logic [Q_W:0]     v_r;
  logic [REM_W-1:0] rem_r  [Q_W+1];
  logic [REM_W-1:0] dvs_r  [Q_W+1];
  logic [Q_W-1:0]   q_r    [Q_W+1];
  logic             ovf_r  [Q_W+1];
  side_t            side_r [Q_W+1];

  logic [REM_W-1:0] x_in, d_in;

  assign x_in = REM_W'(num_mag) << FRAC_BITS;
  assign d_in = REM_W'(den_mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Q_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= x_in;
      dvs_r[0]  <= d_in;
      q_r[0]    <= '0;
      ovf_r[0]  <= (x_in >= (d_in << Q_W));
      side_r[0] <= in_side;
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_bit
    logic [REM_W-1:0] sh;
    logic             take;
    assign sh   = dvs_r[j] << (Q_W - 1 - j);
    assign take = (rem_r[j] >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= take ? (rem_r[j] - sh) : rem_r[j];
        dvs_r[j+1]  <= dvs_r[j];
        q_r[j+1]    <= {q_r[j][Q_W-2:0], take};
        ovf_r[j+1]  <= ovf_r[j];
        side_r[j+1] <= side_r[j];
      end
    end
  end

  assign out_valid = v_r[Q_W];
  assign out_side  = side_r[Q_W];
  assign quot      = ovf_r[Q_W] ? '1 : q_r[Q_W];

endmodule

>>> sv/spi_lerp.sv
module spi_lerp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  spi_pkg::side_t           in_side,
  input  logic [spi_pkg::Q_W-1:0]  quot,
  output logic                     out_valid,
  output spi_pkg::status_t         status,
  output logic [2:0][31:0]         hit
);
  import spi_pkg::*;

  logic [3:1]         v_r;
  logic signed [31:0] t_r;
  side_t              s1_r, s2_r;
  logic signed [64:0] prod_r [3];
  status_t            status_r;
  logic [2:0][31:0]   hit_r;

  logic [31:0]        q_ext;
  logic signed [65:0] sum [3];
  logic [2:0][31:0]   pt;
  logic [2:0][31:0]   hit_nxt;

  assign q_ext = {{(32-Q_W){1'b0}}, quot};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = {{34{s2_r.a[k][31]}}, s2_r.a[k]}
             + {prod_r[k][64], (prod_r[k] >>> FRAC_BITS)};
      if (sum[k][65:31] == '0 || sum[k][65:31] == '1) begin
        pt[k] = sum[k][31:0];
      end else begin
        pt[k] = sum[k][65] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    end
    unique case (s2_r.kind)
      K_POINT:  hit_nxt = pt;
      K_VERT_A: hit_nxt = s2_r.a;
      K_VERT_B: hit_nxt = s2_r.b;
      K_STATUS: hit_nxt = '0;
      default:  hit_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= in_side.zero_t ? '0 : (in_side.neg ? -q_ext : q_ext);
      s1_r <= in_side;
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= $signed(s1_r.dir[k]) * t_r;
      end
      s2_r     <= s1_r;
      status_r <= (s2_r.kind == K_STATUS) ? s2_r.st : ST_INTERSECT;
      hit_r    <= hit_nxt;
    end
  end

  assign out_valid = v_r[3];
  assign status    = status_r;
  assign hit       = hit_r;

endmodule

>>> tb/sv/tb_segment_plane_intersection.sv
`timescale 1ns / 1ps

module tb_segment_plane_intersection;
  import spi_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 39;
  localparam int CFG_EPSILON = 0;
  localparam int CFG_FAST_MODE = 1;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] offs;
    logic signed [31:0] nz;
    logic signed [31:0] ny;
    logic signed [31:0] nx;
    logic signed [31:0] bz;
    logic signed [31:0] by;
    logic signed [31:0] bx;
    logic signed [31:0] az;
    logic signed [31:0] ay;
    logic signed [31:0] ax;
  } segment_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic signed [31:0] hz;
    logic signed [31:0] hy;
    logic signed [31:0] hx;
    status_t            st;
  } hit_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [319:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [103:0] out_tdata;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [15:0] cfg_wdata = '0;

  segment_plane_intersection dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  logic [15:0] eps_reg = 16;
  logic fast_reg = 0;
  segment_t pending_segs[$];
  hit_t expected_hits[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 0;
  int hold_off = 0;
  bit sender_pause = 0;
  bit in_accepted = 0;

  function automatic longint floor_shift(longint v);
    return v >>> FRAC;
  endfunction

  function automatic longint plane_dot(longint p0, longint p1, longint p2,
                                       longint n0, longint n1, longint n2);
    return floor_shift(p0 * n0) + floor_shift(p1 * n1) + floor_shift(p2 * n2);
  endfunction

  function automatic longint unsigned frac_divide(longint unsigned n,
                                                  longint unsigned d,
                                                  longint unsigned cap);
    logic [127:0] wide;
    logic [127:0] q;
    wide = {64'd0, n} << FRAC;
    q = wide / d;
    return (q > cap) ? cap : q[63:0];
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic hit_t predict_hit(segment_t s);
    longint a[3], b[3], dir[3], pa, pb, da, db, den, num, t;
    longint unsigned eps;
    hit_t r;
    a = '{s.ax, s.ay, s.az};
    b = '{s.bx, s.by, s.bz};
    r = '0;
    for (int k = 0; k < 3; k++) dir[k] = b[k] - a[k];
    pa = plane_dot(a[0], a[1], a[2], s.nx, s.ny, s.nz);
    pb = plane_dot(b[0], b[1], b[2], s.nx, s.ny, s.nz);
    da = pa - s.offs;
    db = pb - s.offs;
    den = pb - pa;
    num = -da;
    eps = eps_reg;
    r.st = ST_INTERSECT;
    if (!fast_reg) begin
      if (absval(den) < eps) begin
        r.st = absval(da) < eps ? ST_COPLANAR : ST_DISJOINT;
        return r;
      end
      if (absval(da) < eps || den == 0) begin
        {r.hx, r.hy, r.hz} = {a[0][31:0], a[1][31:0], a[2][31:0]};
        return r;
      end
      if (absval(db) < eps) begin
        {r.hx, r.hy, r.hz} = {b[0][31:0], b[1][31:0], b[2][31:0]};
        return r;
      end
      if ((num != 0 && ((num < 0) != (den < 0))) || absval(num) > absval(den)) begin
        r.st = ST_DISJOINT;
        return r;
      end
      t = frac_divide(absval(num), absval(den), 64'd1 << FRAC);
    end else begin
      t = 0;
      if (den != 0) begin
        t = frac_divide(absval(num), absval(den), 64'h3FFFFFFF);
        if ((num < 0) != (den < 0)) t = -t;
      end
    end
    r.hx = 32'(clamp32(a[0] + floor_shift(dir[0] * t)));
    r.hy = 32'(clamp32(a[1] + floor_shift(dir[1] * t)));
    r.hz = 32'(clamp32(a[2] + floor_shift(dir[2] * t)));
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_accepted) begin
      end else if (!sender_pause && pending_segs.size() > 0
                   && (quiet || $urandom_range(99) >= 17)) begin
        in_tvalid <= 1;
        in_tdata <= pending_segs[0];
        expected_hits.push_back(predict_hit(pending_segs.pop_front()));
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        out_tready <= 0;
        hold_off <= hold_off - 1;
      end else begin
        out_tready <= quiet || $urandom_range(99) >= 17;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    hit_t got, want;
    cycles <= cycles + 1;
    in_accepted <= in_tvalid && in_tready;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_hits.size() == 0) begin
        $display("%0t unexpected transfer %h", $realtime, out_tdata);
        errors++;
      end else begin
        want = expected_hits.pop_front();
        if (got.st !== want.st || got.hx !== want.hx || got.hy !== want.hy
            || got.hz !== want.hz) begin
          $display("%0t mismatch expected st=%0d %h %h %h actual st=%0d %h %h %h",
                   $realtime, want.st, want.hx, want.hy, want.hz,
                   got.st, got.hx, got.hy, got.hz);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord(int sel);
    case (sel)
      0: return $urandom;
      1: return $signed($urandom_range(0, 20 << FRAC)) - (10 << FRAC);
      2: return $signed($urandom_range(0, 4000)) - 2000;
      default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  function automatic segment_t random_seg();
    segment_t s;
    int sel;
    sel = $urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 3);
    s.ax = rand_coord(sel); s.ay = rand_coord(sel); s.az = rand_coord(sel);
    s.bx = rand_coord(sel); s.by = rand_coord(sel); s.bz = rand_coord(sel);
    s.nx = rand_coord(sel); s.ny = rand_coord(sel); s.nz = rand_coord(sel);
    s.offs = rand_coord(sel);
    case ($urandom_range(0, 5))
      0: s.offs = 32'(floor_shift(longint'(s.ax) * s.nx) + floor_shift(longint'(s.ay) * s.ny)
                  + floor_shift(longint'(s.az) * s.nz) + $signed($urandom_range(0, 40)) - 20);
      1: {s.bx, s.by, s.bz} = {s.ax, s.ay, s.az};
      2: begin s.nx = 1 << FRAC; s.ny = 0; s.nz = 0; s.bx = s.ax; end
      default: ;
    endcase
    return s;
  endfunction

  task automatic drain();
    wait (pending_segs.size() == 0 && expected_hits.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= 1'(idx); cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == CFG_EPSILON) eps_reg = val; else fast_reg = val[0];
  endtask

  task automatic run_batch(int n);
    for (int i = 0; i < n; i++) pending_segs.push_back(random_seg());
  endtask

  initial begin
    segment_t s;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed
    s = '0; pending_segs.push_back(s);
    s = '{offs: 0, nz: 1 << FRAC, ny: 0, nx: 0, bz: 5 << FRAC, by: 0, bx: 0,
          az: -(3 << FRAC), ay: 1 << FRAC, ax: 2 << FRAC};
    pending_segs.push_back(s);
    s.offs = 9 << FRAC; pending_segs.push_back(s);
    s.offs = 5 << FRAC; pending_segs.push_back(s);
    s.offs = -(3 << FRAC); pending_segs.push_back(s);
    s.offs = 0; s.bz = -(3 << FRAC); pending_segs.push_back(s);
    s.offs = 7; pending_segs.push_back(s);
    s.az = 2 << FRAC; s.bz = -(6 << FRAC); s.offs = 1 << FRAC; pending_segs.push_back(s);
    s = '{default: 32'h7FFFFFFF}; pending_segs.push_back(s);
    s = '{default: 32'h80000000}; pending_segs.push_back(s);
    s = '{default: 32'hFFFFFFFF}; pending_segs.push_back(s);
    s = '{offs: 32'h80000000, nz: 32'h7FFFFFFF, ny: 32'h80000000, nx: 32'h7FFFFFFF,
          bz: 32'h7FFFFFFF, by: 0, bx: 32'h80000000, az: 32'h80000000, ay: 1, ax: 0};
    pending_segs.push_back(s);
    drain();

    write_reg(CFG_FAST_MODE, 1);
    s = '{offs: 1 << FRAC, nz: 1 << FRAC, ny: 0, nx: 0, bz: 2 << FRAC, by: 0, bx: 0,
          az: 0, ay: 0, ax: 0};
    pending_segs.push_back(s);
    s.bz = 0; pending_segs.push_back(s);
    s.bz = 1; s.az = 0; s.offs = 32'h7FFFFFFF; s.bx = 32'h7FFFFFFF; pending_segs.push_back(s);
    s.bx = 32'h80000000; s.offs = 32'h80000000; pending_segs.push_back(s);
    run_batch(3);
    drain();

    // random, several settings
    write_reg(CFG_FAST_MODE, 0);
    write_reg(CFG_EPSILON, 0);
    run_batch(200);
    drain();
    write_reg(CFG_EPSILON, 16'hFFFF);
    run_batch(200);
    drain();
    write_reg(CFG_EPSILON, 16);
    quiet = 1;
    run_batch(250);
    drain();
    quiet = 0;
    // long receiver stall while the sender keeps offering
    run_batch(200);
    hold_off = 300;
    wait (pending_segs.size() < 100);
    sender_pause = 1;
    wait (expected_hits.size() == 0);
    sender_pause = 0;
    drain();
    write_reg(CFG_EPSILON, $urandom_range(0, 65535));
    run_batch(200);
    drain();
    write_reg(CFG_FAST_MODE, 1);
    run_batch(200);
    drain();
    write_reg(CFG_EPSILON, 1);
    write_reg(CFG_FAST_MODE, 0);
    run_batch(180);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> segment_plane_intersection.f
+incdir+sv
sv/spi_pkg.sv
sv/spi_dot.sv
sv/spi_div.sv
sv/spi_lerp.sv
sv/segment_plane_intersection.sv
tb/sv/tb_segment_plane_intersection.sv
